@@ sv/lqs_pkg.sv @@
// Shared types and constants for the linear queue with search.
// No dependencies; imported by every module of the block except lqs_ram.
package lqs_pkg;

    localparam int DEPTH  = 8;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 32;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_DISPLAY = 2'd2,
        OP_SEARCH  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        op_t                       opcode;
        logic signed [DATA_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  data;
        logic [2:0]                slot;
        logic                      last;
    } out_item_t;

    function automatic logic [2:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+2:0] wide;
        wide = {3'b000, idx};
        return wide[2:0];
    endfunction

endpackage

@@ sv/lqs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/lqs_ctrl.sv @@
// Queue controller: head/tail indices, operation sequencer and entry scan.
// Depends on lqs_pkg; drives one lqs_ram instance and pushes results downstream.
module lqs_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  lqs_pkg::in_item_t              in_item,
    output logic                           ram_we,
    output logic [lqs_pkg::SLOT_W-1:0]     ram_waddr,
    output logic [lqs_pkg::DATA_W-1:0]     ram_wdata,
    output logic                           ram_re,
    output logic [lqs_pkg::SLOT_W-1:0]     ram_raddr,
    input  logic [lqs_pkg::DATA_W-1:0]     ram_rdata,
    output logic                           res_valid,
    input  logic                           res_ready,
    output lqs_pkg::out_item_t             res_item
);
    import lqs_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_CHK
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     head_reg, head_next;
    logic [SLOT_W-1:0]     tail_reg, tail_next;
    logic                  empty_reg, empty_next;
    logic [SLOT_W-1:0]     ptr_reg, ptr_next;
    op_t                   op_reg, op_next;
    logic [DATA_W-1:0]     key_reg, key_next;

    assign in_ready = (state_reg == S_IDLE) && res_ready;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        ptr_next   = ptr_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        ram_we     = 1'b0;
        ram_waddr  = tail_reg;
        ram_wdata  = in_item.value;
        ram_re     = 1'b0;
        ram_raddr  = head_reg;
        res_valid  = 1'b0;
        res_item.status = ST_OK;
        res_item.data   = '0;
        res_item.slot   = '0;
        res_item.last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (in_item.opcode)
                        OP_INSERT:
                        begin
                            res_valid = 1'b1;
                            if (empty_reg)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b0;
                            end
                            else if (tail_reg == LAST_SLOT)
                            begin
                                res_item.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = tail_reg + 1'b1;
                                tail_next = tail_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            if (empty_reg)
                            begin
                                res_valid       = 1'b1;
                                res_item.status = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_reg;
                                ptr_next   = head_reg;
                                op_next    = in_item.opcode;
                                key_next   = in_item.value;
                                state_next = S_CHK;
                            end
                        end
                    endcase
                end
            end
            S_CHK:
            begin
                case (op_reg)
                    OP_DELETE:
                    begin
                        res_valid     = 1'b1;
                        res_item.data = $signed(ram_rdata);
                        if (res_ready)
                        begin
                            state_next = S_IDLE;
                            if (head_reg == tail_reg)
                            begin
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b1;
                            end
                            else
                            begin
                                head_next = head_reg + 1'b1;
                            end
                        end
                    end
                    OP_DISPLAY:
                    begin
                        res_valid     = 1'b1;
                        res_item.data = $signed(ram_rdata);
                        res_item.slot = slot_field(ptr_reg);
                        res_item.last = (ptr_reg == tail_reg);
                        if (res_ready)
                        begin
                            if (ptr_reg == tail_reg)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = ptr_reg + 1'b1;
                                ptr_next  = ptr_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (ram_rdata == key_reg)
                        begin
                            res_valid     = 1'b1;
                            res_item.data = $signed(ram_rdata);
                            res_item.slot = slot_field(ptr_reg);
                            if (res_ready)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else if (ptr_reg == tail_reg)
                        begin
                            res_valid       = 1'b1;
                            res_item.status = ST_NOT_FOUND;
                            if (res_ready)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = ptr_reg + 1'b1;
                            ptr_next  = ptr_reg + 1'b1;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        op_reg  <= op_next;
        key_reg <= key_next;
    end

endmodule

@@ sv/lqs_out.sv @@
// Two-entry result queue between the controller and the output channel.
// Depends on lqs_pkg for the result transaction type.
module lqs_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  lqs_pkg::out_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output lqs_pkg::out_item_t pop_item
);
    import lqs_pkg::*;

    out_item_t   buf_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = buf_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ sv/linear_queue_with_search.sv @@
// Insert writes the RAM and pushes its result into the output queue; delete reads the
// head entry and returns it; display and search scan from the head, one RAM read per
// cycle (display holds while the output queue is full). One transaction in flight; the
// next is taken once all its results sit in the two-entry output queue and it has room.
// Reset: async, active low; clears indices and marks the queue empty. Entry RAM is
// not cleared and needs no clearing pass.
module linear_queue_with_search (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lqs_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output lqs_pkg::out_item_t out_item
);
    import lqs_pkg::*;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;
    logic               res_valid;
    logic               res_ready;
    out_item_t          res_item;

    lqs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    lqs_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_ready (res_ready),
        .push_item  (res_item),
        .pop_valid  (out_valid),
        .pop_ready  (out_ready),
        .pop_item   (out_item)
    );

endmodule

@@ sv/lqs_checker.sv @@
// Port-level checks for linear_queue_with_search, bound to the top level.
// Depends on lqs_pkg for transaction types and status codes.
module lqs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input lqs_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_ready,
    input lqs_pkg::out_item_t out_item
);
    import lqs_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output transaction changed before acceptance");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != ST_OK |-> out_item.last)
        else $error("error status on a non-final result");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != ST_OK |-> out_item.data == 0 && out_item.slot == 0)
        else $error("error result carries data or slot");

    a_ins_clean: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_item.opcode == OP_INSERT |=>
            !out_valid || out_item.status == ST_OK || out_item.status == ST_OVERFLOW
            || $past(out_valid))
        else $error("insert produced an unexpected status");

endmodule

bind linear_queue_with_search lqs_checker u_lqs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
